FILE: rtl/tlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlp_pkg
// Shared constants for the three-axis fixed-point low-pass filter.
// ----------------------------------------------------------------------------
package tlp_pkg;

    // Default fraction bits of the axis accumulators
    localparam int SHIFT_DEF = 8;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int ATT_W    = 9;

    // Attenuation register value after reset (before clamping)
    localparam int ATT_RESET = 64;

    // Number of axes, one lane each
    localparam int AXES = 3;

    // Guard bits above sample width in an accumulator
    localparam int ACC_GUARD = 2;

endpackage : tlp_pkg
`default_nettype wire

FILE: rtl/tlp_sample_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlp_sample_if
// Valid/ready channel carrying one three-axis sample word.
// ----------------------------------------------------------------------------
interface tlp_sample_if import tlp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface : tlp_sample_if
`default_nettype wire

FILE: rtl/tlp_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlp_result_if
// Valid/ready channel carrying one filtered three-axis word.
// ----------------------------------------------------------------------------
interface tlp_result_if import tlp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered_x;
    logic signed [SAMPLE_W-1:0] filtered_y;
    logic signed [SAMPLE_W-1:0] filtered_z;

    modport source (output valid, output filtered_x, output filtered_y, output filtered_z,
                    input ready);
    modport sink   (input valid, input filtered_x, input filtered_y, input filtered_z,
                    output ready);
endinterface : tlp_result_if
`default_nettype wire

FILE: rtl/tlp_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlp_cfg_if
// Valid/ready write channel for the attenuation register.
// ----------------------------------------------------------------------------
interface tlp_cfg_if import tlp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ATT_W-1:0] attenuation;

    modport source (output valid, output attenuation, input ready);
    modport sink   (input valid, input attenuation, output ready);
endinterface : tlp_cfg_if
`default_nettype wire

FILE: rtl/tlp_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlp_lane
// One axis: scaled accumulator with a combinational multiply-accumulate update.
// ----------------------------------------------------------------------------
module tlp_lane import tlp_pkg::*; #(
    parameter int SHIFT = SHIFT_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_load,
    input  wire logic signed [SAMPLE_W-1:0]               i_sample,
    input  wire logic        [SHIFT:0]                    i_att,
    output logic signed      [SHIFT+SAMPLE_W+ACC_GUARD-1:0] o_acc
);
    localparam int AW = SHIFT + SAMPLE_W + ACC_GUARD;  // accumulator width
    localparam int DW = AW + 1 - SHIFT;                // shifted difference
    localparam int PW = DW + SHIFT + 2;                // product width

    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] n_acc;
    logic signed [AW-1:0] scaled;
    logic signed [AW:0]   diff;
    logic signed [DW-1:0] delta;
    logic signed [PW-1:0] prod;

    // sample moved up to accumulator scale
    assign scaled = AW'(i_sample) <<< SHIFT;

    // floor((scaled - acc) / 2^SHIFT) * att, then accumulate
    assign diff  = (AW+1)'(scaled) - (AW+1)'(r_acc);
    assign delta = diff[AW:SHIFT];
    assign prod  = PW'(delta) * PW'($signed({1'b0, i_att}));
    assign n_acc = r_acc + prod[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_load) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule : tlp_lane
`default_nettype wire

FILE: rtl/tlp_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlp_merge
// Rounds and saturates each lane's accumulator and holds the result word.
// ----------------------------------------------------------------------------
module tlp_merge import tlp_pkg::*; #(
    parameter int SHIFT = SHIFT_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_valid,
    input  wire logic signed [SHIFT+SAMPLE_W+ACC_GUARD-1:0] i_acc [AXES],
    output logic                                          o_take,
    tlp_result_if.source                                  o_result
);
    localparam int AW = SHIFT + SAMPLE_W + ACC_GUARD;
    localparam int QW = AW - SHIFT;  // integer part
    localparam int RW = QW + 1;      // after rounding add
    localparam logic signed [RW-1:0] MAXV = RW'((1 << (SAMPLE_W-1)) - 1);
    localparam logic signed [RW-1:0] MINV = RW'(-(1 << (SAMPLE_W-1)));

    logic signed [SAMPLE_W-1:0] sat    [AXES];
    logic signed [SAMPLE_W-1:0] r_word [AXES];
    logic                       r_valid;
    logic                       n_valid;

    // per-lane rounding and saturation
    for (genvar g = 0; g < AXES; g++) begin : g_round
        logic signed [QW-1:0] q;
        logic signed [RW-1:0] rnd;
        assign q   = i_acc[g][AW-1:SHIFT];
        assign rnd = RW'(q) + $signed({{(RW-1){1'b0}}, i_acc[g][SHIFT-1]});
        always_comb begin
            if (rnd > MAXV) begin
                sat[g] = MAXV[SAMPLE_W-1:0];
            end else if (rnd < MINV) begin
                sat[g] = MINV[SAMPLE_W-1:0];
            end else begin
                sat[g] = rnd[SAMPLE_W-1:0];
            end
        end
    end

    // output register: load when empty or being drained
    assign o_take = i_valid && (!r_valid || o_result.ready);

    always_comb begin
        if (o_take) begin
            n_valid = 1'b1;
        end else if (o_result.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_word <= sat;
        end
    end

    assign o_result.valid      = r_valid;
    assign o_result.filtered_x = r_word[0];
    assign o_result.filtered_y = r_word[1];
    assign o_result.filtered_z = r_word[2];

endmodule : tlp_merge
`default_nettype wire

FILE: rtl/three_axis_fixed_point_iir_lowpass.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_fixed_point_iir_lowpass
// First-order fixed-point IIR low-pass over x, y and z accelerometer axes.
// ----------------------------------------------------------------------------
// Accepts one three-axis sample word per clock while the output is not stalled
// and returns one filtered word per sample. Each axis has its own lane whose
// accumulator is updated with one subtract, one multiply by the attenuation and
// one add in the cycle the word is taken; that combinational accumulator loop
// sets the rate of one word per clock. The lane accumulator loads when the
// sample is taken, and the word then passes rounding/saturation into the output
// register once that register is free; one more sample is still taken while a
// finished word waits at the output.
// The attenuation register clamps to 1..2^SHIFT on write and resets to 64
// (clamped); write it only while the filter is idle.
// ----------------------------------------------------------------------------
module three_axis_fixed_point_iir_lowpass import tlp_pkg::*; #(
    parameter int SHIFT = SHIFT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tlp_sample_if.sink    i_sample,
    tlp_cfg_if.sink       i_cfg,
    tlp_result_if.source  o_result
);
    localparam int AW = SHIFT + SAMPLE_W + ACC_GUARD;
    localparam int CW = (SHIFT + 1 > ATT_W) ? SHIFT + 1 : ATT_W;
    localparam int ATT_MAX_I = 1 << SHIFT;
    localparam int ATT_RST_I = (ATT_RESET == 0) ? 1 :
                               ((ATT_RESET > ATT_MAX_I) ? ATT_MAX_I : ATT_RESET);
    localparam logic [SHIFT:0] ATT_RST = ATT_RST_I[SHIFT:0];
    localparam logic [CW-1:0]  ATT_MAX = CW'(ATT_MAX_I);

    logic                       r_s1_valid;
    logic                       n_s1_valid;
    logic                       s1_take;
    logic                       accept;
    logic [SHIFT:0]             r_att;
    logic [CW-1:0]              cfg_wide;
    logic [SHIFT:0]             att_clamped;
    logic signed [SAMPLE_W-1:0] samples [AXES];
    logic signed [AW-1:0]       acc     [AXES];

    // attenuation register, clamped on write
    assign i_cfg.ready = 1'b1;
    assign cfg_wide    = CW'(i_cfg.attenuation);

    always_comb begin
        if (cfg_wide == '0) begin
            att_clamped = (SHIFT+1)'(1);
        end else if (cfg_wide > ATT_MAX) begin
            att_clamped = ATT_MAX[SHIFT:0];
        end else begin
            att_clamped = cfg_wide[SHIFT:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att <= ATT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_att <= att_clamped;
        end
    end

    // input handshake: take a word unless stage one is stuck
    assign i_sample.ready = !r_s1_valid || s1_take;
    assign accept         = i_sample.valid && i_sample.ready;

    always_comb begin
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_take) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // one lane per axis
    assign samples[0] = i_sample.sample_x;
    assign samples[1] = i_sample.sample_y;
    assign samples[2] = i_sample.sample_z;

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        tlp_lane #(
            .SHIFT    (SHIFT)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (accept),
            .i_sample (samples[g]),
            .i_att    (r_att),
            .o_acc    (acc[g])
        );
    end

    // rounding, saturation and output register
    tlp_merge #(
        .SHIFT    (SHIFT)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_acc    (acc),
        .o_take   (s1_take),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_take) |-> !i_sample.ready)
        else $error("input taken while stage one is stalled");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted word did not reach stage one");

    a_take_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_take |=> o_result.valid)
        else $error("stage one word lost on the way to the output");

    a_att_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_att != '0) && (CW'(r_att) <= ATT_MAX))
        else $error("attenuation outside 1..2^SHIFT");
`endif

endmodule : three_axis_fixed_point_iir_lowpass
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-axis fixed-point IIR low-pass filter.
// ----------------------------------------------------------------------------
// Sample words go in through a bursty sender, filtered words come back through
// a receiver that stalls at random and once holds off for a long stretch.
// A cycle-free model of the three lane accumulators predicts every filtered
// word, which is compared axis by axis in arrival order. The attenuation
// register is rewritten between phases while the filter is drained, covering
// the clamped values at both ends.
// ----------------------------------------------------------------------------
module tb;
    import tlp_pkg::*;

    localparam int SHIFT       = SHIFT_DEF;
    localparam int ACC_W       = SHIFT + SAMPLE_W + ACC_GUARD;
    localparam int GAIN_MAX    = 1 << SHIFT;
    localparam int DRAIN_WAIT  = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;

    localparam logic [SAMPLE_W-1:0] S_MAX  = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] S_MIN  = 16'h8000;
    localparam logic [SAMPLE_W-1:0] S_ZERO = 16'h0000;
    localparam logic [SAMPLE_W-1:0] S_ONE  = 16'h0001;
    localparam logic [SAMPLE_W-1:0] S_NEG1 = 16'hFFFF;

    // index 0 is x, 1 is y, 2 is z
    typedef logic [AXES-1:0][SAMPLE_W-1:0] t_axis_triple;

    logic i_clk;
    logic i_rst_n;

    tlp_sample_if sample_ch ();
    tlp_cfg_if    cfg_ch ();
    tlp_result_if result_ch ();

    three_axis_fixed_point_iir_lowpass #(
        .SHIFT (SHIFT)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .i_cfg    (cfg_ch.sink),
        .o_result (result_ch.source)
    );

    // Model state: lane accumulators and the raw attenuation setting
    logic signed [ACC_W-1:0] axis_acc [AXES];
    logic [ATT_W-1:0]        att_setting;

    t_axis_triple filtered_expected_q [$];
    int           mismatch_count = 0;

    // Traffic shaping knobs, set by the tests
    bit sender_gaps   = 1'b0;
    int burst_left    = 0;
    int rx_ready_pct  = 100;
    bit hold_request  = 1'b0;

    string axis_field [AXES] = '{"filtered_x", "filtered_y", "filtered_z"};

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Predict the filtered word for one sample word and advance the lanes
    function automatic t_axis_triple predict_filtered(input t_axis_triple s);
        t_axis_triple res;
        longint       gain;
        longint       scaled;
        longint       acc;
        longint       rounded;
        gain = (att_setting == 0) ? 1 :
               (int'(att_setting) > GAIN_MAX) ? GAIN_MAX : longint'(att_setting);
        for (int i = 0; i < AXES; i++) begin
            scaled = longint'($signed(s[i])) <<< SHIFT;
            acc    = longint'(axis_acc[i]);
            acc    = acc + ((scaled - acc) >>> SHIFT) * gain;
            axis_acc[i] = acc[ACC_W-1:0];
            rounded = (acc >>> SHIFT) + longint'(acc[SHIFT-1]);
            if (rounded > 32767)
                rounded = 32767;
            if (rounded < -32768)
                rounded = -32768;
            res[i] = rounded[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    // Offer one sample word, honoring the burst/gap pattern
    task automatic send_sample(input t_axis_triple s);
        if (sender_gaps && burst_left == 0) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        sample_ch.valid    <= 1'b1;
        sample_ch.sample_x <= s[0];
        sample_ch.sample_y <= s[1];
        sample_ch.sample_z <= s[2];
        do @(posedge i_clk); while (!sample_ch.ready);
        filtered_expected_q.push_back(predict_filtered(s));
    endtask

    // Stop sending and wait until every filtered word is back
    task automatic wait_filter_idle();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (filtered_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_attenuation(input logic [ATT_W-1:0] value);
        wait_filter_idle();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.attenuation <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        att_setting = value;
    endtask

    // Full-scale and near-zero words at the reset attenuation
    task automatic test_sample_extremes();
        send_sample({S_MAX, S_MAX, S_MAX});
        send_sample({S_MAX, S_MAX, S_MAX});
        send_sample({S_MAX, S_MAX, S_MAX});
        send_sample({S_MIN, S_MIN, S_MIN});
        send_sample({S_MIN, S_MIN, S_MIN});
        send_sample({S_NEG1, S_ONE, S_ZERO});
        send_sample({S_ZERO, S_MIN, S_MAX});
        send_sample({S_NEG1, S_MAX, S_MIN});
        send_sample({S_MIN, S_ZERO, S_ONE});
        send_sample({S_ZERO, S_ZERO, S_ZERO});
        wait_filter_idle();
    endtask

    // Zero clamps up to 1, values above full scale clamp to 2^SHIFT
    task automatic test_attenuation_clamp();
        write_attenuation(9'd0);
        send_sample({S_MIN, S_MAX, S_MAX});
        send_sample({S_MIN, S_MAX, S_ONE});
        write_attenuation(9'd511);
        send_sample({S_MAX, S_MIN, 16'd1234});
        send_sample({S_ONE, S_NEG1, 16'd321});
        write_attenuation(9'd257);
        send_sample({S_MAX, 16'hC000, 16'h4000});
        send_sample({S_ZERO, S_MAX, S_MIN});
        write_attenuation(9'd1);
        send_sample({S_MIN, S_MIN, S_MAX});
        send_sample({S_MAX, S_MAX, S_MIN});
        wait_filter_idle();
    endtask

    // Leave fraction bits in the lanes, then jump to full gain at the
    // negative rail so the rounded value falls below 16 bits
    task automatic test_negative_saturation();
        write_attenuation(9'd5);
        send_sample({16'hFFF9, 16'd25, 16'd3});
        write_attenuation(9'd256);
        send_sample({S_MIN, S_MIN, S_MIN});
        send_sample({S_MIN, S_MIN, S_MIN});
        send_sample({S_MIN, S_MIN, S_MIN});
        wait_filter_idle();
    endtask

    // Receiver holds off while the sender keeps offering, then a full drain
    task automatic test_output_backpressure();
        t_axis_triple s;
        sender_gaps  = 1'b0;
        rx_ready_pct = 100;
        hold_request = 1'b1;
        for (int n = 0; n < 40; n++) begin
            s = {16'($urandom), 16'($urandom), 16'($urandom)};
            send_sample(s);
        end
        wait_filter_idle();
    endtask

    // Phases of random words under several attenuation settings
    task automatic test_random_streams();
        t_axis_triple     s;
        t_axis_triple     base;
        int               v;
        logic [ATT_W-1:0] att_list [8];
        att_list = '{9'd1, 9'd256, 9'd0, 9'd511,
                     9'($urandom_range(2, 255)), 9'($urandom_range(257, 510)),
                     9'd64, 9'($urandom_range(0, 511))};
        base = {16'($urandom), 16'($urandom), 16'($urandom)};
        for (int ph = 0; ph < 8; ph++) begin
            write_attenuation(att_list[ph]);
            sender_gaps  = (ph % 3) != 0;
            rx_ready_pct = (ph % 4 == 0) ? 100 : $urandom_range(30, 95);
            for (int n = 0; n < 75; n++) begin
                for (int i = 0; i < AXES; i++) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: s[i] = 16'($urandom);
                        8: begin
                            base[i] = 16'($urandom);
                            s[i]    = base[i];
                        end
                        9: begin
                            case ($urandom_range(0, 3))
                                0: s[i] = S_MAX;
                                1: s[i] = S_MIN;
                                2: s[i] = S_ZERO;
                                default: s[i] = S_NEG1;
                            endcase
                        end
                        default: begin
                            // slowly wandering signal with small noise
                            v = int'($signed(base[i])) + int'($urandom_range(0, 1023)) - 512;
                            if (v > 32767)
                                v = 32767;
                            if (v < -32768)
                                v = -32768;
                            s[i] = v[SAMPLE_W-1:0];
                        end
                    endcase
                end
                send_sample(s);
            end
        end
        wait_filter_idle();
    endtask

    // Stimulus sequence
    initial begin
        i_rst_n            <= 1'b0;
        sample_ch.valid    <= 1'b0;
        sample_ch.sample_x <= '0;
        sample_ch.sample_y <= '0;
        sample_ch.sample_z <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.attenuation <= '0;
        for (int i = 0; i < AXES; i++)
            axis_acc[i] = '0;
        att_setting = ATT_W'(ATT_RESET);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sample_extremes();
        test_attenuation_clamp();
        test_negative_saturation();
        test_output_backpressure();
        test_random_streams();

        wait_filter_idle();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result checker and receiver stall pattern
    initial begin : result_checker
        t_axis_triple got;
        t_axis_triple want;
        int           hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready) begin
                got = {result_ch.filtered_z, result_ch.filtered_y, result_ch.filtered_x};
                if (filtered_expected_q.size() == 0) begin
                    $error("filtered word with no sample pending: x=%0d y=%0d z=%0d",
                           $signed(got[0]), $signed(got[1]), $signed(got[2]));
                    mismatch_count++;
                end else begin
                    want = filtered_expected_q.pop_front();
                    for (int i = 0; i < AXES; i++) begin
                        if (got[i] !== want[i]) begin
                            $error("%s: expected %0d, actual %0d", axis_field[i],
                                   $signed(want[i]), $signed(got[i]));
                            mismatch_count++;
                        end
                    end
                end
            end
            // next cycle's ready
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) < rx_ready_pct);
            end
        end
    end

    // Watchdog: too long with no word moving on any channel
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((sample_ch.valid && sample_ch.ready) ||
                (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $error("no word moved for %0d cycles, %0d filtered words outstanding",
               STALL_LIMIT, filtered_expected_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule : tb

FILE: files.f
rtl/tlp_pkg.sv
rtl/tlp_sample_if.sv
rtl/tlp_result_if.sv
rtl/tlp_cfg_if.sv
rtl/tlp_lane.sv
rtl/tlp_merge.sv
rtl/three_axis_fixed_point_iir_lowpass.sv
tb/sv/tb.sv
